// ===== rtl/core/zsr_pkg.sv =====
package zsr_pkg;

  localparam int MAX_DIM     = 16;
  localparam int DIM_W       = $clog2(MAX_DIM + 1);
  localparam int IDX_W       = $clog2(MAX_DIM);
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int VALUE_W     = 32;
  localparam int APB_DW      = 32;
  localparam int APB_AW      = 3;
  localparam int OUT_DW      = 40;

  localparam logic [DIM_W-1:0] ROW_COUNT_RESET    = DIM_W'(8);
  localparam logic [DIM_W-1:0] COLUMN_COUNT_RESET = DIM_W'(8);

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_EMIT = 1'b1
  } func_t;

  typedef enum logic {
    REG_ROW_COUNT    = 1'b0,
    REG_COLUMN_COUNT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] column;
    logic             last;
  } scan_pos_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

endpackage

// ===== rtl/core/zigzag_scan_reorder_core.sv =====
// Zigzag scan reorder buffer.
// Input stream (s_*): s_tuser selects the item kind, 0 = load, 1 = emit.
// A load writes s_tdata into the element store in row-major order; the load
// pointer wraps after clamped row_count * column_count. A load gives no result.
// An emit reads the element at the current zigzag position and gives one result
// on the output stream (m_*): value, row and column in m_tdata, and m_tlast on
// the final element of a scan, after which the scan restarts at the top-left.
// A result reaches m_tvalid through the registered read of the element store
// and then the output register. Throughput: one item per cycle while m_tready
// is high, as each item either writes or reads the element store, and so the
// store is never read and written in one cycle.
// When the receiver stalls, the result held in the output register stays and one
// further emit may sit behind it; s_tready then drops until the output drains.
// Reset clears the load pointer and scan position and sets both dimensions to 8;
// the store contents are undefined until written. Writing either register over
// the APB port restarts the load pointer and the scan; write only while idle.
module zigzag_scan_reorder_core
  import zsr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [VALUE_W-1:0] s_tdata,   // element_value[31:0]
  input  logic               s_tuser,   // func[0]
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OUT_DW-1:0]  m_tdata,   // out_value[31:0], out_row[35:32], out_column[39:36]
  output logic               m_tlast,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  logic [DIM_W-1:0]  row_count;
  logic [DIM_W-1:0]  column_count;
  logic [DIM_W-1:0]  rows;
  logic [DIM_W-1:0]  cols;
  logic [CNT_W-1:0]  total;
  logic              cfg_wr;
  logic              restart;
  logic              in_acc;
  logic              load_acc;
  logic              emit_acc;
  logic              move;
  logic              pend;
  scan_pos_t         pend_pos;
  scan_pos_t         pos;
  logic [ADDR_W-1:0] rd_addr;
  logic [VALUE_W-1:0] rd_data;
  logic [ADDR_W-1:0] load_pointer;
  logic [ADDR_W-1:0] wr_addr;
  logic [CNT_W-1:0]  load_pointer_inc;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign restart = cfg_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= ROW_COUNT_RESET;
      column_count <= COLUMN_COUNT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_ROW_COUNT:    row_count    <= pwdata[DIM_W-1:0];
        REG_COLUMN_COUNT: column_count <= pwdata[DIM_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_ROW_COUNT:    prdata = {{(APB_DW-DIM_W){1'b0}}, row_count};
      REG_COLUMN_COUNT: prdata = {{(APB_DW-DIM_W){1'b0}}, column_count};
      default:          prdata = '0;
    endcase
  end

  assign rows  = clamp_dim(row_count);
  assign cols  = clamp_dim(column_count);
  assign total = CNT_W'(rows) * CNT_W'(cols);

  assign move     = !m_tvalid || m_tready;
  assign s_tready = !pend || move;
  assign in_acc   = s_tvalid && s_tready;
  assign load_acc = in_acc && (s_tuser == FUNC_LOAD);
  assign emit_acc = in_acc && (s_tuser == FUNC_EMIT);

  assign wr_addr = (CNT_W'(load_pointer) >= total) ? '0 : load_pointer;
  assign load_pointer_inc = CNT_W'(wr_addr) + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      load_pointer <= '0;
    end else if (load_acc) begin
      load_pointer <= (load_pointer_inc >= total) ? '0 : load_pointer_inc[ADDR_W-1:0];
    end
  end

  zsr_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .restart (restart),
    .advance (emit_acc),
    .rows    (rows),
    .cols    (cols),
    .pos     (pos),
    .addr    (rd_addr)
  );

  zsr_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (load_acc),
    .waddr (wr_addr),
    .wdata (s_tdata),
    .re    (emit_acc),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (emit_acc) begin
      pend <= 1'b1;
    end else if (move) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_acc) begin
      pend_pos <= pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (move) begin
      m_tvalid <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (move && pend) begin
      m_tdata <= {pend_pos.column, pend_pos.row, rd_data};
      m_tlast <= pend_pos.last;
    end
  end

endmodule

// ===== rtl/core/zsr_ram.sv =====
module zsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/zsr_scan.sv =====
module zsr_scan
  import zsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  logic              advance,
  input  logic [DIM_W-1:0]  rows,
  input  logic [DIM_W-1:0]  cols,
  output scan_pos_t         pos,
  output logic [ADDR_W-1:0] addr
);

  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] column;
  logic             moving_down;
  logic [IDX_W-1:0] row_next;
  logic [IDX_W-1:0] column_next;
  logic             moving_down_next;
  logic [IDX_W-1:0] end_row;
  logic [IDX_W-1:0] end_col;
  logic [IDX_W-1:0] cur_row;
  logic [IDX_W-1:0] cur_col;
  logic             cur_down;
  logic             last;
  logic [ADDR_W+DIM_W-1:0] lin;

  assign end_row = IDX_W'(rows - DIM_W'(1));
  assign end_col = IDX_W'(cols - DIM_W'(1));

  always_comb begin
    cur_row  = row;
    cur_col  = column;
    cur_down = moving_down;
    if (row > end_row || column > end_col) begin
      cur_row  = '0;
      cur_col  = '0;
      cur_down = 1'b0;
    end
  end

  assign last = (cur_row == end_row) && (cur_col == end_col);
  assign lin  = (ADDR_W+DIM_W)'(cur_row) * (ADDR_W+DIM_W)'(cols)
              + (ADDR_W+DIM_W)'(cur_col);
  assign addr = lin[ADDR_W-1:0];

  assign pos.row    = cur_row;
  assign pos.column = cur_col;
  assign pos.last   = last;

  always_comb begin
    row_next         = cur_row;
    column_next      = cur_col;
    moving_down_next = cur_down;
    if (last) begin
      row_next         = '0;
      column_next      = '0;
      moving_down_next = 1'b0;
    end else if (!cur_down) begin
      if (cur_col == end_col) begin
        row_next         = cur_row + IDX_W'(1);
        moving_down_next = 1'b1;
      end else if (cur_row == '0) begin
        column_next      = cur_col + IDX_W'(1);
        moving_down_next = 1'b1;
      end else begin
        row_next    = cur_row - IDX_W'(1);
        column_next = cur_col + IDX_W'(1);
      end
    end else begin
      if (cur_row == end_row) begin
        column_next      = cur_col + IDX_W'(1);
        moving_down_next = 1'b0;
      end else if (cur_col == '0) begin
        row_next         = cur_row + IDX_W'(1);
        moving_down_next = 1'b0;
      end else begin
        row_next    = cur_row + IDX_W'(1);
        column_next = cur_col - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row         <= '0;
      column      <= '0;
      moving_down <= 1'b0;
    end else if (advance) begin
      row         <= row_next;
      column      <= column_next;
      moving_down <= moving_down_next;
    end
  end

endmodule

// ===== rtl/core/zsr_checker.sv =====
module zsr_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pready
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  a_restart_origin: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid || (m_tdata[39:32] == 8'h00))
    else $error("scan did not restart at the top-left corner");

  a_apb_ready: assert property (@(posedge clk) disable iff (rst)
    psel && penable |-> pready)
    else $error("access phase without pready");

endmodule

bind zigzag_scan_reorder_core zsr_checker u_zsr_checker (.*);

// ===== dv/zigzag_scan_reorder_core_tb.sv =====
module zigzag_scan_reorder_core_tb;
  import zsr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET   = 1500;
  localparam int SETTLE_CYCLES = 4;
  localparam int GAP_MAX       = 12;
  localparam int LONG_HOLD     = 300;
  localparam int HOLD_AFTER    = 150;
  localparam int STALL_LIMIT   = 2000;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   column;
    logic               last;
  } zz_element_t;

  class zigzag_tracker;
    logic [VALUE_W-1:0] store [STORE_DEPTH];
    bit                 written [STORE_DEPTH];
    logic [4:0]         row_reg;
    logic [4:0]         col_reg;
    int                 load_ptr;
    int                 scan_row;
    int                 scan_col;
    bit                 moving_down;
    zz_element_t        expected_elements[$];
    int                 accepted;
    int                 checked;
    int                 errors;

    function new();
      foreach (written[i]) written[i] = 1'b0;
      row_reg  = ROW_COUNT_RESET;
      col_reg  = COLUMN_COUNT_RESET;
      accepted = 0;
      checked  = 0;
      errors   = 0;
      restart();
    endfunction

    function void restart();
      load_ptr    = 0;
      scan_row    = 0;
      scan_col    = 0;
      moving_down = 1'b0;
    endfunction

    function int dim(logic [4:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
    endfunction

    function void write_reg(reg_idx_t idx, logic [APB_DW-1:0] data);
      if (idx == REG_ROW_COUNT) row_reg = data[4:0];
      else col_reg = data[4:0];
      restart();
    endfunction

    function int pending();
      return expected_elements.size();
    endfunction

    // True when the next emit would read an entry already loaded.
    function bit emit_ready();
      int rows;
      int cols;
      int r;
      int c;
      rows = dim(row_reg);
      cols = dim(col_reg);
      r = scan_row;
      c = scan_col;
      if (r > rows - 1 || c > cols - 1) begin
        r = 0;
        c = 0;
      end
      return written[r * cols + c];
    endfunction

    function void accept_item(func_t f, logic [VALUE_W-1:0] v);
      int rows;
      int cols;
      int end_row;
      int end_col;
      bit last;
      zz_element_t e;
      rows = dim(row_reg);
      cols = dim(col_reg);
      end_row = rows - 1;
      end_col = cols - 1;
      accepted++;
      if (f == FUNC_LOAD) begin
        if (load_ptr >= rows * cols) load_ptr = 0;
        store[load_ptr]   = v;
        written[load_ptr] = 1'b1;
        load_ptr++;
        if (load_ptr >= rows * cols) load_ptr = 0;
        return;
      end
      if (scan_row > end_row || scan_col > end_col) begin
        scan_row    = 0;
        scan_col    = 0;
        moving_down = 1'b0;
      end
      last     = (scan_row == end_row) && (scan_col == end_col);
      e.value  = store[scan_row * cols + scan_col];
      e.row    = IDX_W'(scan_row);
      e.column = IDX_W'(scan_col);
      e.last   = last;
      expected_elements.insert(expected_elements.size(), e);
      if (last) begin
        scan_row    = 0;
        scan_col    = 0;
        moving_down = 1'b0;
      end else if (!moving_down) begin
        if (scan_col == end_col) begin
          scan_row++;
          moving_down = 1'b1;
        end else if (scan_row == 0) begin
          scan_col++;
          moving_down = 1'b1;
        end else begin
          scan_row--;
          scan_col++;
        end
      end else begin
        if (scan_row == end_row) begin
          scan_col++;
          moving_down = 1'b0;
        end else if (scan_col == 0) begin
          scan_row++;
          moving_down = 1'b0;
        end else begin
          scan_row++;
          scan_col--;
        end
      end
    endfunction

    function void compare_element(logic [OUT_DW-1:0] data, logic last_flag);
      zz_element_t e;
      logic [IDX_W-1:0] got_row;
      logic [IDX_W-1:0] got_col;
      got_row = data[VALUE_W +: IDX_W];
      got_col = data[VALUE_W + IDX_W +: IDX_W];
      checked++;
      if (expected_elements.size() == 0) begin
        $error("unexpected element: data %h, tlast %b", data, last_flag);
        errors++;
        return;
      end
      e = expected_elements.pop_front();
      if (data[VALUE_W-1:0] !== e.value) begin
        $error("out_value: expected %h, got %h", e.value, data[VALUE_W-1:0]);
        errors++;
      end
      if (got_row !== e.row) begin
        $error("out_row: expected %0d, got %0d", e.row, got_row);
        errors++;
      end
      if (got_col !== e.column) begin
        $error("out_column: expected %0d, got %0d", e.column, got_col);
        errors++;
      end
      if (last_flag !== e.last) begin
        $error("scan_last: expected %b, got %b", e.last, last_flag);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [VALUE_W-1:0] s_tdata;
  logic s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_DW-1:0] m_tdata;
  logic m_tlast;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  zigzag_tracker tracker;
  int tx_gap_max = GAP_MAX;
  int rx_gap_max = GAP_MAX;

  zigzag_scan_reorder_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && tracker != null) begin
      if (m_tvalid && m_tready) tracker.compare_element(m_tdata, m_tlast);
      if (s_tvalid && s_tready) tracker.accept_item(func_t'(s_tuser), s_tdata);
      if (psel && penable && pwrite && pready)
        tracker.write_reg(reg_idx_t'(paddr[2]), pwdata);
    end
  end

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [4:0] pick_dim();
    case ($urandom_range(0, 11))
      0: return 5'd0;
      1: return 5'($urandom_range(MAX_DIM, 31));
      default: return 5'($urandom_range(1, 6));
    endcase
  endfunction

  // Call at a falling edge; leaves tvalid high for a back-to-back item.
  task automatic send_item(func_t f, logic [VALUE_W-1:0] v);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_gap_max = (tx_gap_max == 0) ? GAP_MAX : 0;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop tvalid and drain all pending elements before returning.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(reg_idx_t idx, logic [4:0] raw);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= (APB_DW'($urandom) & ~APB_DW'(32'h1f)) | APB_DW'(raw);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_dims(logic [4:0] rows, logic [4:0] cols, bit write_cols);
    settle();
    apb_write(REG_ROW_COUNT, rows);
    if (write_cols) apb_write(REG_COLUMN_COUNT, cols);
  endtask

  task automatic run_phase(int budget);
    int n;
    int done;
    int burst;
    func_t f;
    n = tracker.dim(tracker.row_reg) * tracker.dim(tracker.col_reg);
    done = 0;
    while (done < budget) begin
      if ($urandom_range(0, 9) < 7) begin
        repeat (n) send_item(FUNC_LOAD, pick_value());
        repeat (n) send_item(FUNC_EMIT, pick_value());
        done += 2 * n;
      end else begin
        burst = $urandom_range(1, 8);
        repeat (burst) begin
          f = func_t'($urandom_range(0, 1));
          if (f == FUNC_EMIT && !tracker.emit_ready()) f = FUNC_LOAD;
          send_item(f, pick_value());
        end
        done += burst;
      end
    end
  endtask

  initial begin : receiver
    bit held;
    int gap;
    held = 1'b0;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) rx_gap_max = (rx_gap_max == 0) ? GAP_MAX : 0;
      gap = $urandom_range(0, rx_gap_max);
      if (!held && tracker.checked >= HOLD_AFTER) begin
        held = 1'b1;
        gap = LONG_HOLD;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    tracker  = new();
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = FUNC_LOAD;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // 1x1 from zero registers: every element ends a scan
    set_dims(5'd0, 5'd0, 1'b1);
    send_item(FUNC_LOAD, 32'h8000_0000);
    send_item(FUNC_EMIT, 32'hffff_ffff);
    send_item(FUNC_EMIT, 32'h0000_0000);
    send_item(FUNC_LOAD, 32'h7fff_ffff);
    send_item(FUNC_EMIT, 32'h5555_5555);

    // single row, scan wraps
    set_dims(5'd1, 5'd4, 1'b1);
    send_item(FUNC_LOAD, 32'h0000_0000);
    send_item(FUNC_LOAD, 32'hffff_ffff);
    send_item(FUNC_LOAD, 32'h5555_5555);
    send_item(FUNC_LOAD, 32'haaaa_aaaa);
    repeat (5) send_item(FUNC_EMIT, 32'haaaa_aaaa);

    // single column
    set_dims(5'd3, 5'd1, 1'b1);
    send_item(FUNC_LOAD, 32'h8000_0001);
    send_item(FUNC_LOAD, 32'h7fff_fffe);
    send_item(FUNC_LOAD, 32'h0000_0001);
    repeat (3) send_item(FUNC_EMIT, 32'h0);

    // full size, with column register above range
    set_dims(5'd16, 5'd31, 1'b1);
    run_phase(1);

    while (tracker.accepted < ITEM_TARGET) begin
      set_dims(pick_dim(), pick_dim(), $urandom_range(0, 3) != 0);
      run_phase($urandom_range(40, 120));
    end

    settle();
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
